[rtl/core/ipv4_dotted_decimal_parser_defines.svh]
// assertion macros for the ipv4 dotted-decimal parser
// no dependencies; included by the top level only
`ifndef IPV4_DOTTED_DECIMAL_PARSER_DEFINES_SVH
`define IPV4_DOTTED_DECIMAL_PARSER_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define IPV4DP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ipv4 parser check failed");

// implication with the consequent checked in the cycle after the antecedent
`define IPV4DP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv4 parser sequencing check failed");

`else

`define IPV4DP_ASSERT(lbl, clk, rst_n, prop)
`define IPV4DP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/ipv4dp_pkg.sv]
// shared types and constants for the ipv4 dotted-decimal parser
// no dependencies
`default_nettype none

package ipv4dp_pkg;

    // ascii codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_DIG_LO = 8'd48;
    localparam logic [7:0] CH_DIG_HI = 8'd57;

    // octet limits
    localparam logic [8:0] OCT_SAT     = 9'd256;
    localparam logic [8:0] OCT_MAX     = 9'd255;
    localparam logic [1:0] DIGIT_MAX   = 2'd3;
    localparam logic [2:0] OCTET_COUNT = 3'd4;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FIRST_ZERO = 3'd1,
        ST_LEAD_ZERO  = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_OVER       = 3'd4,
        ST_BAD_CHAR   = 3'd5,
        ST_COUNT      = 3'd6
    } status_t;

    // parse state carried between characters
    typedef struct packed {
        logic [8:0]  octet_value;
        logic [1:0]  digit_count;
        logic        first_digit_zero;
        logic [2:0]  octet_index;
        logic [31:0] packed_address;
        status_t     error_code;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        octet_value:      9'd0,
        digit_count:      2'd0,
        first_digit_zero: 1'b0,
        octet_index:      3'd0,
        packed_address:   32'd0,
        error_code:       ST_OK
    };

endpackage

`default_nettype wire

[rtl/core/ipv4dp_step.sv]
// next-state and result logic for one character of the address string
// depends on ipv4dp_pkg
`default_nettype none

module ipv4dp_step
    import ipv4dp_pkg::*;
(
    input  wire parse_state_t state_cur,
    input  wire logic [7:0]   char_code,
    input  wire logic         is_last,
    output parse_state_t      state_next,
    output logic [31:0]       address,
    output status_t           status
);

    // finish the current octet: check it, pack it, clear the accumulator
    function automatic parse_state_t close_octet(input parse_state_t s);
        parse_state_t t;
        t = s;
        if (s.error_code == ST_OK)
        begin
            if (s.digit_count == 2'd0)
            begin
                t.error_code = ST_EMPTY;
            end
            else if (s.octet_value > OCT_MAX)
            begin
                t.error_code = ST_OVER;
            end
            else if (s.octet_index >= OCTET_COUNT)
            begin
                t.error_code = ST_COUNT;
            end
            else
            begin
                t.packed_address = {s.packed_address[23:0], s.octet_value[7:0]};
                t.octet_index    = s.octet_index + 3'd1;
            end
            t.octet_value      = 9'd0;
            t.digit_count      = 2'd0;
            t.first_digit_zero = 1'b0;
        end
        return t;
    endfunction

    parse_state_t after_char;
    parse_state_t after_close;
    logic         is_digit;
    logic [3:0]   digit;
    logic [12:0]  acc_ext;
    logic [12:0]  acc_prod;
    logic         take_digit;

    // digit decode and times-ten accumulate
    always_comb
    begin
        is_digit = (char_code >= CH_DIG_LO) && (char_code <= CH_DIG_HI);
        digit    = 4'(char_code - CH_DIG_LO);
        acc_ext  = {4'd0, state_cur.octet_value};
        acc_prod = (acc_ext << 3) + (acc_ext << 1) + {9'd0, digit};
    end

    // per-character update
    always_comb
    begin
        after_char = state_cur;
        take_digit = 1'b0;
        if (state_cur.error_code == ST_OK)
        begin
            if (is_digit)
            begin
                if (state_cur.digit_count == 2'd0)
                begin
                    if ((char_code == CH_ZERO) && (state_cur.octet_index == 3'd0))
                    begin
                        after_char.error_code = ST_FIRST_ZERO;
                    end
                    else
                    begin
                        after_char.first_digit_zero = (digit == 4'd0);
                        take_digit = 1'b1;
                    end
                end
                else if (state_cur.first_digit_zero)
                begin
                    after_char.error_code = ST_LEAD_ZERO;
                end
                else
                begin
                    take_digit = 1'b1;
                end
                if (take_digit)
                begin
                    after_char.octet_value = (acc_prod > {4'd0, OCT_SAT})
                                           ? OCT_SAT : acc_prod[8:0];
                    if (state_cur.digit_count < DIGIT_MAX)
                    begin
                        after_char.digit_count = state_cur.digit_count + 2'd1;
                    end
                end
            end
            else if (char_code == CH_DOT)
            begin
                after_char = close_octet(state_cur);
            end
            else
            begin
                after_char.error_code = ST_BAD_CHAR;
            end
        end
    end

    // end of string: close the last octet, check the count, report
    always_comb
    begin
        after_close = close_octet(after_char);
        if ((after_close.error_code == ST_OK) && (after_close.octet_index != OCTET_COUNT))
        begin
            after_close.error_code = ST_COUNT;
        end
        status  = after_close.error_code;
        address = (after_close.error_code == ST_OK) ? after_close.packed_address : 32'd0;
        state_next = is_last ? PARSE_STATE_RESET : after_char;
    end

endmodule

`default_nettype wire

[rtl/core/ipv4_dotted_decimal_parser.sv]
// IPv4 dotted-decimal parser. Characters of an address string enter one per
// beat on the input channel, is_last set on the final character. Beats are
// accepted at one per cycle unless a last character is stalled: a character
// is held in the input register, then the step logic updates the parse state
// and, on the last character, loads the result register, which offers the
// result (address and status). Only a result waiting in the output register
// while out_ready is low holds back the next last character, which then also
// holds the characters behind it; ordinary characters ahead keep flowing.
// Address reads zero whenever status is not ok.
// depends on ipv4dp_pkg, ipv4dp_step and ipv4_dotted_decimal_parser_defines.svh
`default_nettype none
`include "ipv4_dotted_decimal_parser_defines.svh"

module ipv4_dotted_decimal_parser
    import ipv4dp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      address,
    output logic [2:0]       status
);

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic [31:0]  address_reg;
    status_t      status_reg;
    logic [31:0]  address_next;
    status_t      status_next;
    logic         out_free;
    logic         advance;

    // flow control: only a last character needs the result register free
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_code;
            last_reg <= is_last;
        end
    end

    // parse step
    ipv4dp_step u_step (
        .state_cur  (state_reg),
        .char_code  (char_reg),
        .is_last    (last_reg),
        .state_next (state_next),
        .address    (address_next),
        .status     (status_next)
    );

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            address_reg <= address_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign status    = status_reg;

    // checks
    `IPV4DP_ASSERT(a_addr_zero_on_error, clk, rst_n,
        !out_valid_reg || (status_reg == ST_OK) || (address_reg == 32'd0))
    `IPV4DP_ASSERT(a_index_bound, clk, rst_n, state_reg.octet_index <= OCTET_COUNT)
    `IPV4DP_ASSERT(a_empty_octet_zero, clk, rst_n,
        (state_reg.digit_count != 2'd0) || (state_reg.octet_value == 9'd0))
    `IPV4DP_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && last_reg,
        out_valid_reg && (state_reg.octet_index == 3'd0)
        && (state_reg.error_code == ST_OK) && (state_reg.digit_count == 2'd0))

endmodule

`default_nettype wire

[test/ipv4_dotted_decimal_parser_check.sv]
// checker for the ipv4 dotted-decimal parser: watches both channels, predicts
// each address result from the accepted characters and compares it on arrival
// depends on ipv4dp_pkg
module ipv4_dotted_decimal_parser_check
    import ipv4dp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        is_last,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] address,
    input  wire logic [2:0]  status,
    output int               mismatches,
    output int               pending_results,
    output int               results_checked,
    output int               ok_results,
    output logic [6:0]       codes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] address;
        status_t     status;
    } parse_result_t;

    parse_state_t  parse_state;
    parse_result_t result_queue[$];
    int            mismatch_count = 0;
    int            queued_count   = 0;
    int            checked_count  = 0;
    int            ok_count       = 0;
    logic [6:0]    seen_mask      = '0;

    assign mismatches      = mismatch_count;
    assign pending_results = queued_count;
    assign results_checked = checked_count;
    assign ok_results      = ok_count;
    assign codes_seen      = seen_mask;

    // close the current octet on a dot or at the end of the string
    function automatic void close_octet();
        if (parse_state.error_code == ST_OK) begin
            if (parse_state.digit_count == 2'd0)
                parse_state.error_code = ST_EMPTY;
            else if (parse_state.octet_value > OCT_MAX)
                parse_state.error_code = ST_OVER;
            else if (parse_state.octet_index >= OCTET_COUNT)
                parse_state.error_code = ST_COUNT;
            else begin
                parse_state.packed_address = {parse_state.packed_address[23:0],
                                              parse_state.octet_value[7:0]};
                parse_state.octet_index = parse_state.octet_index + 3'd1;
            end
            parse_state.octet_value      = 9'd0;
            parse_state.digit_count      = 2'd0;
            parse_state.first_digit_zero = 1'b0;
        end
    endfunction

    // fold one accepted character into the parse, queue the address on the last
    function automatic void parse_char(input logic [7:0] c, input logic last);
        int unsigned   acc;
        parse_result_t done;
        // a latched error swallows everything up to the last character
        if (parse_state.error_code != ST_OK) begin
        end else if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
            if (parse_state.digit_count == 2'd0 && c == CH_ZERO
                    && parse_state.octet_index == 3'd0)
                parse_state.error_code = ST_FIRST_ZERO;
            else if (parse_state.digit_count != 2'd0 && parse_state.first_digit_zero)
                parse_state.error_code = ST_LEAD_ZERO;
            else begin
                if (parse_state.digit_count == 2'd0)
                    parse_state.first_digit_zero = (c == CH_ZERO);
                acc = parse_state.octet_value * 10 + (c - CH_DIG_LO);
                parse_state.octet_value = (acc > OCT_SAT) ? OCT_SAT : acc[8:0];
                if (parse_state.digit_count != DIGIT_MAX)
                    parse_state.digit_count = parse_state.digit_count + 2'd1;
            end
        end else if (c == CH_DOT) begin
            close_octet();
        end else begin
            parse_state.error_code = ST_BAD_CHAR;
        end

        if (last) begin
            close_octet();
            if (parse_state.error_code == ST_OK && parse_state.octet_index != OCTET_COUNT)
                parse_state.error_code = ST_COUNT;
            done.status  = parse_state.error_code;
            done.address = (parse_state.error_code == ST_OK) ?
                           parse_state.packed_address : 32'd0;
            result_queue.push_back(done);
            queued_count = queued_count + 1;
            parse_state = PARSE_STATE_RESET;
        end
    endfunction

    // predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n) begin : watch
        parse_result_t want;
        if (!rst_n) begin
            parse_state = PARSE_STATE_RESET;
            result_queue.delete();
            queued_count = 0;
        end else begin
            if (in_valid && in_ready)
                parse_char(char_code, is_last);

            if (out_valid && out_ready) begin
                checked_count = checked_count + 1;
                if (status <= ST_COUNT)
                    seen_mask[status] = 1'b1;
                if (queued_count == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: address %h status %0d",
                                 address, status);
                end else begin
                    want = result_queue.pop_front();
                    queued_count = queued_count - 1;
                    if (want.status == ST_OK)
                        ok_count = ok_count + 1;
                    if (address !== want.address || status !== want.status) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("result %0d: address %h want %h, status %0d want %0d",
                                     checked_count, address, want.address,
                                     status, want.status);
                    end
                end
            end
        end
    end

endmodule

[test/ipv4_dotted_decimal_parser_test.sv]
// top of the parser testbench: clock, reset, character and ready stimulus, verdict
// depends on ipv4dp_pkg, the parser rtl and ipv4_dotted_decimal_parser_check
module ipv4_dotted_decimal_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4dp_pkg::*;

    localparam int CHAR_TARGET  = 1500;
    localparam int QUIET_TAIL   = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        OCT_LEAD_ZERO,
        OCT_BIG,
        OCT_HUGE,
        OCT_EMPTY,
        OCT_PLAIN
    } octet_form_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  char_code = 8'd0;
    logic        is_last   = 1'b0;
    logic        out_ready = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [31:0] address;
    wire  [2:0]  status;

    int          mismatches;
    int          pending_results;
    int          results_checked;
    int          ok_results;
    logic [6:0]  codes_seen;

    bit [7:0]    text_q[$];
    int          chars_sent    = 0;
    int          strings_sent  = 0;
    int          cycle_count   = 0;
    int          hold_requests = 0;
    int          holds_done    = 0;
    bit          sender_idling = 1'b0;
    bit          ready_idling  = 1'b0;

    ipv4_dotted_decimal_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .address   (address),
        .status    (status)
    );

    ipv4_dotted_decimal_parser_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .char_code       (char_code),
        .is_last         (is_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .address         (address),
        .status          (status),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .ok_results      (ok_results),
        .codes_seen      (codes_seen)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                holds_done = holds_done + 1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (ready_idling && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // append the decimal digits of a value
    function automatic void push_number(input int unsigned value);
        int unsigned scale;
        scale = 1;
        while (scale * 10 <= value)
            scale = scale * 10;
        while (scale != 0)
        begin
            text_q.push_back(8'(CH_DIG_LO + (value / scale) % 10));
            scale = scale / 10;
        end
    endfunction

    function automatic void push_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // mostly well-formed addresses, the rest broken in the ways the parser flags
    function automatic void build_random_string();
        bit          clean;
        bit          all_max;
        int unsigned octets;
        int unsigned value;
        int unsigned pick;
        octet_form_t form;
        clean   = ($urandom_range(0, 9) < 6);
        all_max = ($urandom_range(0, 15) == 0);
        if (!clean && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 6))
                text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        octets = (clean || $urandom_range(0, 2) != 0) ? 4 : $urandom_range(1, 6);
        for (int i = 0; i < octets; i++)
        begin
            if (i != 0)
                text_q.push_back(CH_DOT);
            pick = $urandom_range(0, 7);
            form = (clean || pick > OCT_PLAIN) ? OCT_PLAIN : octet_form_t'(pick);
            case (form)
                OCT_LEAD_ZERO:
                begin
                    text_q.push_back(CH_ZERO);
                    push_number($urandom_range(0, 255));
                end
                OCT_BIG:   push_number($urandom_range(256, 999));
                OCT_HUGE:  push_number($urandom_range(1000, 99999));
                OCT_EMPTY: ;
                default:
                begin
                    if (all_max)
                        value = 255;
                    else if ($urandom_range(0, 3) == 0)
                        value = $urandom_range(0, 1) * 255;
                    else
                        value = $urandom_range(0, 255);
                    // keep most first octets from tripping the zero rule
                    if (i == 0 && value == 0 && $urandom_range(0, 3) != 0)
                        value = 1;
                    push_number(value);
                end
            endcase
        end
        if (text_q.size() == 0)
            text_q.push_back(CH_DOT);
        if (!clean && $urandom_range(0, 3) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        if (!clean && $urandom_range(0, 5) == 0)
            text_q.push_back(CH_DOT);
    endfunction

    // offer one character beat and hold it until taken
    task automatic send_beat(input logic [7:0] c, input logic last);
        bit taken;
        if (sender_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        chars_sent = chars_sent + 1;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        strings_sent = strings_sent + 1;
    endtask

    task automatic wait_for_results();
        do
            @(negedge clk);
        while (pending_results != 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        bit paused;
        bit second_hold;
        bit quiet;
        paused      = 1'b0;
        second_hold = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one string per status, byte extremes
        push_string("0");
        send_text();
        push_string("1");
        send_text();
        push_string(".");
        send_text();
        text_q.push_back(8'h00);
        push_string(".");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        push_string("1.01");
        send_text();
        push_string("256");
        send_text();
        push_string("9.0.0.255");
        send_text();

        // random strings, long receiver hold-off first to back up the input
        hold_requests = hold_requests + 1;
        while (chars_sent < CHAR_TARGET)
        begin
            quiet         = (chars_sent >= QUIET_TAIL);
            sender_idling = !quiet && ((chars_sent / 150) % 4 != 3);
            ready_idling  = !quiet && ((chars_sent / 150) % 4 != 2);
            if (!paused && chars_sent >= CHAR_TARGET / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                wait_for_results();
            end
            if (!second_hold && chars_sent >= 1000)
            begin
                second_hold = 1'b1;
                hold_requests = hold_requests + 1;
            end
            build_random_string();
            send_text();
        end
        in_valid <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results != 0)
            $display("%0d results never arrived", pending_results);
        $display("run covered %0d characters in %0d strings, %0d results checked",
                 chars_sent, strings_sent, results_checked);
        $display("%0d valid addresses, %0d of 7 status codes seen, %0d mismatches",
                 ok_results, $countones(codes_seen), mismatches);
        if (mismatches == 0 && pending_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
